>>> hdl/mclwd_pkg.sv
// shared types, constants and codes of the multi-channel liveness watchdog
package mclwd_pkg;

    localparam int DEF_SLOTS       = 8;
    localparam int DEF_VALUE_BYTES = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int SLOT_W  = 6;
    localparam int TICK_W  = 32;
    localparam int DATA_W  = 64;
    localparam int LEN_W   = 8;
    localparam int HNDL_W  = 8;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KICK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP    = 2'd2;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_KICK     = 2'd1,
        OP_SWEEP    = 2'd2
    } op_cls_t;

    typedef struct packed {
        op_cls_t             cls;
        logic                too_long;
        logic [TICK_W-1:0]   now;
        logic [SLOT_W-1:0]   handle;
        logic [TICK_W-1:0]   period;
        logic [DATA_W-1:0]   value;
    } op_t;

    typedef struct packed {
        logic                strobe;
        logic                kind;
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   value;
        logic                last;
    } result_t;

endpackage

>>> hdl/mclwd_ram.sv
// generic single-write, single-read ram with registered read data
module mclwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mclwd_queue.sv
// short command queue between the front and back parts
module mclwd_queue #(
    parameter int DEPTH = mclwd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mclwd_pkg::op_t  wdata,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output mclwd_pkg::op_t  rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mclwd_pkg::op_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hdl/mclwd_front.sv
// front part: takes command words, classifies them and masks the fallback
module mclwd_front #(
    parameter int SLOTS       = mclwd_pkg::DEF_SLOTS,
    parameter int VALUE_BYTES = mclwd_pkg::DEF_VALUE_BYTES
) (
    input  logic                            start,
    output logic                            busy,
    input  logic [mclwd_pkg::CMD_W-1:0]     cmd,
    input  logic [mclwd_pkg::TICK_W-1:0]    now_tick,
    input  logic [mclwd_pkg::HNDL_W-1:0]    slot_handle,
    input  logic [mclwd_pkg::TICK_W-1:0]    period_ticks,
    input  logic [mclwd_pkg::DATA_W-1:0]    fallback_data,
    input  logic [mclwd_pkg::LEN_W-1:0]     fallback_length,
    input  logic                            q_full,
    output logic                            push,
    output mclwd_pkg::op_t                  op
);

    logic keep;

    assign busy = q_full;
    assign push = start && !q_full && keep;

    always_comb
    begin
        op          = '0;
        keep        = 1'b0;
        op.now      = now_tick;
        op.handle   = slot_handle[mclwd_pkg::SLOT_W-1:0];
        op.period   = period_ticks;
        op.too_long = (fallback_length > mclwd_pkg::LEN_W'(VALUE_BYTES));
        for (int b = 0; b < 8; b++)
        begin
            if ((b < VALUE_BYTES) && (mclwd_pkg::LEN_W'(b) < fallback_length))
            begin
                op.value[b*8 +: 8] = fallback_data[b*8 +: 8];
            end
        end
        case (cmd)
            mclwd_pkg::CMD_REGISTER:
            begin
                op.cls = mclwd_pkg::OP_REGISTER;
                keep   = 1'b1;
            end
            mclwd_pkg::CMD_KICK:
            begin
                // out-of-range handles are dropped here
                op.cls = mclwd_pkg::OP_KICK;
                keep   = ({1'b0, slot_handle} < (mclwd_pkg::HNDL_W + 1)'(SLOTS));
            end
            mclwd_pkg::CMD_SWEEP:
            begin
                op.cls = mclwd_pkg::OP_SWEEP;
                keep   = 1'b1;
            end
            default:
            begin
                op.cls = mclwd_pkg::OP_SWEEP;
                keep   = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/mclwd_back.sv
// back part: slot table, register scan and sweep walk, result register
module mclwd_back #(
    parameter int SLOTS       = mclwd_pkg::DEF_SLOTS,
    parameter int VALUE_BYTES = mclwd_pkg::DEF_VALUE_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  mclwd_pkg::op_t      head,
    output logic                pop,
    output mclwd_pkg::result_t  res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int VAL_W = VALUE_BYTES * 8;
    localparam int N_W   = $clog2(mclwd_pkg::MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [VAL_W-1:0]    pend_value_reg, pend_value_next;
    logic [N_W-1:0]      found_reg, found_next;
    mclwd_pkg::op_t      work_reg, work_next;
    mclwd_pkg::result_t  res_reg, res_next;

    logic                lk_we, cfg_we;
    logic [IDX_W-1:0]    waddr;
    logic [mclwd_pkg::TICK_W-1:0] lk_wdata;
    logic [IDX_W-1:0]    raddr;
    logic [mclwd_pkg::TICK_W-1:0] lk_rdata, pr_rdata;
    logic [VAL_W-1:0]    fb_rdata;
    logic [mclwd_pkg::TICK_W-1:0] elapsed;
    logic                expired;

    mclwd_ram #(.WIDTH(mclwd_pkg::TICK_W), .DEPTH(SLOTS)) u_last_kick (
        .clk   (clk),
        .we    (lk_we),
        .waddr (waddr),
        .wdata (lk_wdata),
        .raddr (raddr),
        .rdata (lk_rdata)
    );

    mclwd_ram #(.WIDTH(mclwd_pkg::TICK_W), .DEPTH(SLOTS)) u_period (
        .clk   (clk),
        .we    (cfg_we),
        .waddr (waddr),
        .wdata (work_reg.period),
        .raddr (raddr),
        .rdata (pr_rdata)
    );

    mclwd_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_fallback (
        .clk   (clk),
        .we    (cfg_we),
        .waddr (waddr),
        .wdata (work_reg.value[VAL_W-1:0]),
        .raddr (raddr),
        .rdata (fb_rdata)
    );

    assign raddr   = rd_cnt_reg[IDX_W-1:0];
    assign elapsed = work_reg.now - lk_rdata;
    assign expired = used_reg[ev_idx_reg] && (elapsed > pr_rdata);
    assign res     = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        rd_cnt_next     = rd_cnt_reg;
        ev_valid_next   = 1'b0;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_value_next = pend_value_reg;
        found_next      = found_reg;
        work_next       = work_reg;
        res_next        = '0;
        pop             = 1'b0;
        lk_we           = 1'b0;
        cfg_we          = 1'b0;
        waddr           = idx_reg;
        lk_wdata        = work_reg.now;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (head.cls)
                        mclwd_pkg::OP_KICK:
                        begin
                            lk_we    = 1'b1;
                            waddr    = head.handle[IDX_W-1:0];
                            lk_wdata = head.now;
                        end
                        mclwd_pkg::OP_REGISTER:
                        begin
                            if (head.too_long)
                            begin
                                res_next.strobe = 1'b1;
                                res_next.kind   = mclwd_pkg::KIND_REPLY;
                                res_next.last   = 1'b1;
                            end
                            else
                            begin
                                work_next  = head;
                                idx_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        mclwd_pkg::OP_SWEEP:
                        begin
                            work_next       = head;
                            rd_cnt_next     = '0;
                            pend_valid_next = 1'b0;
                            found_next      = '0;
                            state_next      = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!used_reg[idx_reg])
                begin
                    lk_we              = 1'b1;
                    cfg_we             = 1'b1;
                    used_next[idx_reg] = 1'b1;
                    res_next.strobe    = 1'b1;
                    res_next.kind      = mclwd_pkg::KIND_REPLY;
                    res_next.accepted  = 1'b1;
                    res_next.slot      = mclwd_pkg::SLOT_W'(idx_reg);
                    res_next.last      = 1'b1;
                    state_next         = ST_IDLE;
                end
                else if (idx_reg == IDX_W'(SLOTS - 1))
                begin
                    res_next.strobe = 1'b1;
                    res_next.kind   = mclwd_pkg::KIND_REPLY;
                    res_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SWEEP:
            begin
                if (rd_cnt_reg < CNT_W'(SLOTS))
                begin
                    ev_valid_next = 1'b1;
                    ev_idx_next   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (ev_valid_reg)
                begin
                    if (expired)
                    begin
                        // the older find goes out now, the newest one waits
                        if (pend_valid_reg)
                        begin
                            res_next.strobe   = 1'b1;
                            res_next.kind     = mclwd_pkg::KIND_EXPIRED;
                            res_next.accepted = 1'b1;
                            res_next.slot     = mclwd_pkg::SLOT_W'(pend_slot_reg);
                            res_next.value    = mclwd_pkg::DATA_W'(pend_value_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = ev_idx_reg;
                        pend_value_next = fb_rdata;
                        found_next      = found_reg + N_W'(1);
                        if (found_reg + N_W'(1) == N_W'(mclwd_pkg::MAX_RESULTS))
                        begin
                            ev_valid_next = 1'b0;
                            state_next    = ST_FLUSH;
                        end
                    end
                    if (ev_idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        ev_valid_next = 1'b0;
                        state_next    = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    res_next.strobe   = 1'b1;
                    res_next.kind     = mclwd_pkg::KIND_EXPIRED;
                    res_next.accepted = 1'b1;
                    res_next.slot     = mclwd_pkg::SLOT_W'(pend_slot_reg);
                    res_next.value    = mclwd_pkg::DATA_W'(pend_value_reg);
                    res_next.last     = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            idx_reg        <= '0;
            rd_cnt_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            found_reg      <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            rd_cnt_reg     <= rd_cnt_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            found_reg      <= found_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg        <= ev_idx_next;
        pend_slot_reg     <= pend_slot_next;
        pend_value_reg    <= pend_value_next;
        work_reg          <= work_next;
    end

endmodule

>>> hdl/multi_channel_liveness_watchdog.sv
// top level of the multi-channel liveness watchdog
//
// a table of SLOTS watchdog channels, all unused after reset. a command word
// is taken on a clock edge with start high and busy low. cmd 0 registers a
// channel in the lowest free slot and answers with one reply word (slot, or
// accepted low when the table is full or the fallback is longer than
// VALUE_BYTES bytes). cmd 1 kicks a slot and gives no word; cmd 3 and kicks
// of handles at or above SLOTS are swallowed. cmd 2 sweeps the table and
// sends one word per expired used slot, lowest slot first, at most eight,
// with last high on the final one; a sweep with nothing expired sends
// nothing. results come out on strobe for exactly one cycle and cannot be
// held off. a kick writes its tick into the last-kick ram; a register
// scans for the lowest free slot, checking one slot a cycle; a sweep
// reads the rams one slot at a time (read data is registered), stops
// at the eighth find and then flushes the final word. a two-word queue
// sits between intake and execution, so busy only rises when two words
// wait behind the one being worked on.
module multi_channel_liveness_watchdog #(
    parameter int SLOTS       = mclwd_pkg::DEF_SLOTS,
    parameter int VALUE_BYTES = mclwd_pkg::DEF_VALUE_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [mclwd_pkg::CMD_W-1:0]     cmd,
    input  logic [mclwd_pkg::TICK_W-1:0]    now_tick,
    input  logic [mclwd_pkg::HNDL_W-1:0]    slot_handle,
    input  logic [mclwd_pkg::TICK_W-1:0]    period_ticks,
    input  logic [mclwd_pkg::DATA_W-1:0]    fallback_data,
    input  logic [mclwd_pkg::LEN_W-1:0]     fallback_length,
    output logic                            strobe,
    output logic                            kind,
    output logic                            accepted,
    output logic [mclwd_pkg::SLOT_W-1:0]    slot,
    output logic [mclwd_pkg::DATA_W-1:0]    emitted_value,
    output logic                            last
);

    // queue handshake between intake and execution
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    mclwd_pkg::op_t      front_op;
    mclwd_pkg::op_t      head_op;
    mclwd_pkg::result_t  res;

    // intake: classify, drop ignored words, mask fallback bytes
    mclwd_front #(
        .SLOTS       (SLOTS),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_front (
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .now_tick        (now_tick),
        .slot_handle     (slot_handle),
        .period_ticks    (period_ticks),
        .fallback_data   (fallback_data),
        .fallback_length (fallback_length),
        .q_full          (q_full),
        .push            (q_push),
        .op              (front_op)
    );

    mclwd_queue #(
        .DEPTH (mclwd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (front_op),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (head_op)
    );

    // execution: slot table, scans and sweeps
    mclwd_back #(
        .SLOTS       (SLOTS),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head_op),
        .pop     (q_pop),
        .res     (res)
    );

    // result word straight from the output register
    assign strobe        = res.strobe;
    assign kind          = res.kind;
    assign accepted      = res.accepted;
    assign slot          = res.slot;
    assign emitted_value = res.value;
    assign last          = res.last;

endmodule
